[hdl/wsd_pkg.sv]
// ---------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Holds the parse phase encoding, result record and protocol constants.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int LEN_WIDTH_DEF = 64;

    localparam logic [31:0] MAX_LEN_RST   = 32'd4194304;
    localparam logic [6:0]  SHORT_LEN_MAX = 7'd125;
    localparam logic [6:0]  EXT16_CODE    = 7'd126;
    localparam logic [3:0]  MASK_BYTES    = 4'd4;
    localparam logic [3:0]  EXT16_BYTES   = 4'd2;
    localparam logic [3:0]  EXT64_BYTES   = 4'd8;

    localparam logic [3:0]  OP_CLOSE = 4'h8;
    localparam logic [3:0]  OP_PING  = 4'h9;
    localparam logic [3:0]  OP_PONG  = 4'hA;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXT     = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [3:0] opcode;
        logic       fin;
        logic       was_masked;
        logic       frame_end;
        logic       length_error;
    } t_result;

    // Registered input byte handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] in_byte;
    } t_in_req;

    // Parser request into the result register
    typedef struct packed {
        logic    push;
        t_result res;
    } t_out_req;

endpackage

[hdl/wsd_if.sv]
// ---------------------------------------------------------------------------
// wsd_in_if / wsd_out_if: valid/ready stream channels
// Input channel carries one stream byte, output channel one result.
// ---------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] opcode;
    logic       fin;
    logic       was_masked;
    logic       frame_end;
    logic       length_error;

    modport source (output valid, output data_byte, output has_data, output opcode,
                    output fin, output was_masked, output frame_end,
                    output length_error, input ready);
    modport sink   (input valid, input data_byte, input has_data, input opcode,
                    input fin, input was_masked, input frame_end,
                    input length_error, output ready);
endinterface

[hdl/websocket_frame_deframer_top.sv]
// A byte goes from the input register through the parser into the result register, and waits in the input
// register while the result register is full. Throughput: one byte per cycle while the result register is free;
// the parser's one-pass state update sets this rate. A byte gives one result if it carries delivered payload
// or completes a header with zero length, a length error or a control opcode; others none. Reset (i_rst_n low,
// synchronous) empties both registers, returns the parser to the first header byte and loads max_len with 4194304.
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top: WebSocket receive-side frame deframer
// Parses frame headers from a byte stream and delivers unmasked payload bytes.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top #(
    parameter int LEN_WIDTH = wsd_pkg::LEN_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    wsd_in_if.sink      i_in_chan,
    wsd_out_if.source   o_out_chan
);
    import wsd_pkg::*;

    t_in_req  in_req;
    t_out_req out_req;
    logic     take;
    logic     out_free;

    wsd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (i_in_chan),
        .i_take    (take),
        .o_req     (in_req)
    );

    wsd_parser #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (in_req),
        .i_out_free    (out_free),
        .o_take        (take),
        .o_out         (out_req)
    );

    wsd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_out      (out_req),
        .o_free     (out_free),
        .o_out_chan (o_out_chan)
    );

endmodule

[hdl/wsd_in_stage.sv]
// ---------------------------------------------------------------------------
// wsd_in_stage: input byte register
// Captures one stream byte and holds it until the parser consumes it.
// ---------------------------------------------------------------------------
module wsd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsd_in_if.sink            i_in_chan,
    input  logic              i_take,
    output wsd_pkg::t_in_req  o_req
);
    import wsd_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       load;

    // Accept a new request when empty or when the held byte leaves this cycle
    assign i_in_chan.ready = !r_valid || i_take;
    assign load            = i_in_chan.valid && i_in_chan.ready;
    assign n_valid         = load ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the byte payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_in_chan.in_byte;
        end
    end

    assign o_req.valid   = r_valid;
    assign o_req.in_byte = r_byte;

endmodule

[hdl/wsd_parser.sv]
// ---------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// Walks the header fields, tracks the payload count and unmasks data bytes.
// ---------------------------------------------------------------------------
module wsd_parser #(
    parameter int LEN_WIDTH = wsd_pkg::LEN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  wsd_pkg::t_in_req   i_req,
    input  logic               i_out_free,
    output logic               o_take,
    output wsd_pkg::t_out_req  o_out
);
    import wsd_pkg::*;

    localparam int CMP_W = (LEN_WIDTH > 32) ? LEN_WIDTH : 32;

    logic [31:0]          r_max_len;
    t_phase               r_phase,       n_phase;
    logic [3:0]           r_head_opcode, n_head_opcode;
    logic                 r_head_fin,    n_head_fin;
    logic                 r_mask_on,     n_mask_on;
    logic [3:0]           r_ext_left,    n_ext_left;
    logic [LEN_WIDTH-1:0] r_remaining,   n_remaining;
    logic [31:0]          r_mask_key,    n_mask_key;
    logic [1:0]           r_key_index,   n_key_index;
    logic                 r_skip,        n_skip;

    logic [7:0]           b;
    logic [LEN_WIDTH-1:0] len_short;
    logic [LEN_WIDTH-1:0] len_shift;
    logic [LEN_WIDTH-1:0] len_cand;
    logic [LEN_WIDTH-1:0] rem_dec;
    logic                 lerr;
    logic                 ctrl;
    logic                 hdr_done;
    logic [7:0]           key_byte;
    t_result              res;
    logic                 push;

    assign b      = i_req.in_byte;
    assign o_take = i_req.valid && i_out_free;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    // Length candidates: short length, or saturating shift-in of an extended byte
    assign len_short = LEN_WIDTH'(b[6:0]);
    always_comb begin
        if (|r_remaining[LEN_WIDTH-1 -: 8]) begin
            len_shift = '1;
        end else begin
            len_shift = {r_remaining[LEN_WIDTH-9:0], b};
        end
    end

    always_comb begin
        priority if (r_phase == PH_HDR1) begin
            len_cand = len_short;
        end else if (r_phase == PH_EXT) begin
            len_cand = len_shift;
        end else begin
            len_cand = r_remaining;
        end
    end

    // Length check against the limit, ceiling always rejected
    assign lerr = (CMP_W'(len_cand) > CMP_W'(r_max_len)) || (&len_cand);
    assign ctrl = (r_head_opcode == OP_CLOSE) || (r_head_opcode == OP_PING)
               || (r_head_opcode == OP_PONG);
    assign rem_dec = (r_remaining != '0) ? (r_remaining - 1'b1) : r_remaining;

    // Select the key byte for the current payload position
    always_comb begin
        unique case (r_key_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    // Next state and result
    always_comb begin
        n_phase       = r_phase;
        n_head_opcode = r_head_opcode;
        n_head_fin    = r_head_fin;
        n_mask_on     = r_mask_on;
        n_ext_left    = r_ext_left;
        n_remaining   = r_remaining;
        n_mask_key    = r_mask_key;
        n_key_index   = r_key_index;
        n_skip        = r_skip;
        hdr_done      = 1'b0;
        push          = 1'b0;
        res           = '0;
        res.opcode    = r_head_opcode;
        res.fin       = r_head_fin;

        if (o_take) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_mask_on  = b[7];
                    n_mask_key = '0;
                    if (b[6:0] <= SHORT_LEN_MAX) begin
                        n_remaining = len_short;
                        if (b[7]) begin
                            n_ext_left = MASK_BYTES;
                            n_phase    = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end else begin
                        n_remaining = '0;
                        n_ext_left  = (b[6:0] == EXT16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                        n_phase     = PH_EXT;
                    end
                end
                PH_EXT: begin
                    n_remaining = len_shift;
                    n_ext_left  = r_ext_left - 1'b1;
                    if (n_ext_left == '0) begin
                        if (r_mask_on) begin
                            n_ext_left = MASK_BYTES;
                            n_phase    = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], b};
                    n_ext_left = r_ext_left - 1'b1;
                    if (n_ext_left == '0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_remaining = rem_dec;
                    if (r_skip) begin
                        if (rem_dec == '0) begin
                            n_skip  = 1'b0;
                            n_phase = PH_HDR0;
                        end
                    end else begin
                        n_key_index   = r_key_index + 1'b1;
                        if (rem_dec == '0) begin
                            n_phase = PH_HDR0;
                        end
                        push          = 1'b1;
                        res.data_byte = r_mask_on ? (b ^ key_byte) : b;
                        res.has_data  = 1'b1;
                        res.frame_end = (rem_dec == '0);
                    end
                end
                default: begin
                    n_head_fin    = b[7];
                    n_head_opcode = b[3:0];
                    n_phase       = PH_HDR1;
                end
            endcase

            // Close the header: emit a header-only result, enter the payload to deliver it, or do both and skip it
            if (hdr_done) begin
                n_key_index = '0;
                if ((len_cand == '0) || lerr || ctrl) begin
                    push             = 1'b1;
                    res.frame_end    = 1'b1;
                    res.length_error = lerr;
                    if (len_cand == '0) begin
                        n_skip  = 1'b0;
                        n_phase = PH_HDR0;
                    end else begin
                        n_skip  = 1'b1;
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_skip  = 1'b0;
                    n_phase = PH_PAYLOAD;
                end
            end
        end

        res.was_masked = n_mask_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_head_opcode <= '0;
            r_head_fin    <= 1'b0;
            r_mask_on     <= 1'b0;
            r_ext_left    <= '0;
            r_remaining   <= '0;
            r_mask_key    <= '0;
            r_key_index   <= '0;
            r_skip        <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_head_opcode <= n_head_opcode;
            r_head_fin    <= n_head_fin;
            r_mask_on     <= n_mask_on;
            r_ext_left    <= n_ext_left;
            r_remaining   <= n_remaining;
            r_mask_key    <= n_mask_key;
            r_key_index   <= n_key_index;
            r_skip        <= n_skip;
        end
    end

    assign o_out.push = push;
    assign o_out.res  = res;

endmodule

[hdl/wsd_out_stage.sv]
// ---------------------------------------------------------------------------
// wsd_out_stage: result register
// Holds one result until the consumer takes it; frees itself on the handshake.
// ---------------------------------------------------------------------------
module wsd_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsd_pkg::t_out_req  i_out,
    output logic               o_free,
    wsd_out_if.source          o_out_chan
);
    import wsd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held request is taken this cycle
    assign o_free  = !r_valid || o_out_chan.ready;
    assign n_valid = i_out.push ? 1'b1 : (o_out_chan.ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (i_out.push) begin
            r_res <= i_out.res;
        end
    end

    assign o_out_chan.valid        = r_valid;
    assign o_out_chan.data_byte    = r_res.data_byte;
    assign o_out_chan.has_data     = r_res.has_data;
    assign o_out_chan.opcode       = r_res.opcode;
    assign o_out_chan.fin          = r_res.fin;
    assign o_out_chan.was_masked   = r_res.was_masked;
    assign o_out_chan.frame_end    = r_res.frame_end;
    assign o_out_chan.length_error = r_res.length_error;

endmodule

[hdl/wsd_checker.sv]
// ---------------------------------------------------------------------------
// wsd_checker: port-level checks for the deframer
// Watches the result channel for stall, reset and field consistency.
// ---------------------------------------------------------------------------
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic       i_has_data,
    input logic       i_frame_end,
    input logic       i_length_error
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_data_byte)))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Header-only results carry a zero data byte
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_has_data) |-> (i_data_byte == 8'd0))
        else $error("data byte nonzero without payload");

    // A length error is a header-only result that ends the frame
    a_lerr_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_length_error) |-> (i_frame_end && !i_has_data))
        else $error("length error on a payload result");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_chan.valid),
    .i_out_ready    (o_out_chan.ready),
    .i_data_byte    (o_out_chan.data_byte),
    .i_has_data     (o_out_chan.has_data),
    .i_frame_end    (o_out_chan.frame_end),
    .i_length_error (o_out_chan.length_error)
);

[verif/websocket_frame_deframer_top_test.sv]
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top_test: self-checking bench for the frame deframer
// Streams WebSocket frames into the deframer under random backpressure and
// checks every result against a cycle-free software deframer.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top_test;
    import wsd_pkg::*;

    localparam int LEN_W          = LEN_WIDTH_DEF;
    localparam logic [63:0] LEN_CEIL = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_W);
    localparam logic [6:0]  EXT64_CODE = 7'd127;
    localparam logic [3:0]  OP_CONT    = 4'h0;
    localparam logic [3:0]  OP_TEXT    = 4'h1;
    localparam logic [3:0]  OP_BIN     = 4'h2;
    localparam logic [3:0]  OP_RSV_F   = 4'hF;
    localparam int IDLE_LO        = 16;
    localparam int IDLE_HI        = 85;
    localparam int SEG_BYTES      = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_e;

    // One frame of stimulus; typed rows carry their header-only result
    typedef struct packed {
        bit          set_cfg;
        logic [31:0] cfg;
        bit          fin;
        logic [2:0]  rsv;
        logic [3:0]  op;
        bit          masked;
        len_form_e   form;
        logic [63:0] len;
        logic [31:0] key;
        int unsigned npay;
        bit          typed;
        bit          lerr;
    } frame_t;

    typedef struct packed {
        bit      typed;
        t_result res;
    } byte_tag_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    wsd_in_if  in_if ();
    wsd_out_if out_if ();

    websocket_frame_deframer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_chan     (in_if),
        .o_out_chan    (out_if)
    );

    // Software deframer state
    t_phase      ph;
    logic [3:0]  cur_op;
    logic        cur_fin;
    logic        cur_masked;
    logic [3:0]  hdr_left;
    logic [63:0] len_left;
    logic [31:0] key_word;
    logic [1:0]  key_pos;
    logic        dropping;
    logic [31:0] lim_len;

    t_result     exp_results [$];
    byte_tag_t   pending_tags [$];
    int          mismatches   = 0;
    int          bytes_sent   = 0;
    int          idle_cycles  = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic [31:0] cur_max_len  = MAX_LEN_RST;

    // Directed frames: reset limit, every named opcode, length forms, limit edges
    frame_t dir_frames [12] = '{
        '{0, 0,            1, 3'b000, OP_TEXT,  0, LEN_SHORT, 0, 0,            0, 1, 0},
        '{0, 0,            0, 3'b000, OP_BIN,   1, LEN_SHORT, 1, 32'hA5C3_0F81, 1, 0, 0},
        '{0, 0,            1, 3'b000, OP_PING,  0, LEN_SHORT, 1, 0,            1, 1, 0},
        '{0, 0,            1, 3'b000, OP_PONG,  1, LEN_SHORT, 0, 32'h1234_5678, 0, 1, 0},
        '{0, 0,            1, 3'b000, OP_CLOSE, 1, LEN_SHORT, 2, 32'hFFFF_FFFF, 2, 1, 0},
        '{0, 0,            0, 3'b111, OP_RSV_F, 1, LEN_EXT16, 1, 32'h8000_0001, 1, 0, 0},
        '{0, 0,            1, 3'b000, OP_CONT,  0, LEN_EXT64, 2, 0,            2, 0, 0},
        '{1, 0,            1, 3'b000, OP_TEXT,  0, LEN_SHORT, 1, 0,            1, 1, 1},
        '{0, 0,            1, 3'b000, OP_BIN,   1, LEN_SHORT, 0, 0,            0, 1, 0},
        '{1, 5,            0, 3'b101, OP_TEXT,  1, LEN_SHORT, 5, 32'h5A5A_C33C, 5, 0, 0},
        '{0, 0,            1, 3'b000, OP_BIN,   0, LEN_EXT16, 6, 0,            6, 1, 1},
        '{1, 32'hFFFF_FFFF, 1, 3'b010, OP_BIN,   1, LEN_EXT64, 3, 32'hDEAD_BEEF, 3, 0, 0}
    };

    // Saturated 64-bit length: always rejected, and its skip never ends
    frame_t ceil_frame = '{0, 0, 1, 3'b000, OP_BIN, 1, LEN_EXT64,
                           64'hFFFF_FFFF_FFFF_FFFF, 32'h0F0F_F0F0, 6, 1, 1};

    logic [31:0] seg_lims [9] = '{32'hFFFF_FFFF, 8, 0, 64, MAX_LEN_RST, 1, 125, 200, 3};

    always #5 i_clk = ~i_clk;

    function automatic t_result header_only(input logic [3:0] op, input logic fin,
                                            input logic masked, input logic lerr);
        t_result r;
        r              = '0;
        r.opcode       = op;
        r.fin          = fin;
        r.was_masked   = masked;
        r.frame_end    = 1'b1;
        r.length_error = lerr;
        return r;
    endfunction

    // Close the header: judge the length, decide deliver / drop / done
    function automatic bit close_header(output t_result r);
        logic lerr;
        logic ctrl;
        lerr = (len_left > {32'd0, lim_len}) || (len_left == LEN_CEIL);
        ctrl = (cur_op == OP_CLOSE) || (cur_op == OP_PING) || (cur_op == OP_PONG);
        key_pos = 2'd0;
        r = '0;
        if (len_left == 64'd0 || lerr || ctrl) begin
            r = header_only(cur_op, cur_fin, cur_masked, lerr);
            dropping = (len_left != 64'd0);
            ph = (len_left == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
            return 1'b1;
        end
        dropping = 1'b0;
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the software deframer by one stream byte
    function automatic bit deframe_step(input logic [7:0] b, output t_result r);
        logic [6:0]  len7;
        logic [7:0]  d;
        logic [63:0] v;
        r = '0;
        case (ph)
            PH_HDR1: begin
                len7       = b[6:0];
                cur_masked = b[7];
                key_word   = '0;
                len_left   = '0;
                if (len7 <= SHORT_LEN_MAX) begin
                    len_left = {57'd0, len7};
                end else begin
                    hdr_left = (len7 == EXT16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                    ph = PH_EXT;
                    return 1'b0;
                end
                if (cur_masked) begin
                    hdr_left = MASK_BYTES;
                    ph = PH_MASK;
                    return 1'b0;
                end
                return close_header(r);
            end
            PH_EXT: begin
                if (len_left > (LEN_CEIL >> 8)) begin
                    len_left = LEN_CEIL;
                end else begin
                    v = (len_left << 8) | {56'd0, b};
                    len_left = (v > LEN_CEIL) ? LEN_CEIL : v;
                end
                hdr_left = hdr_left - 4'd1;
                if (hdr_left != 4'd0) return 1'b0;
                if (cur_masked) begin
                    hdr_left = MASK_BYTES;
                    ph = PH_MASK;
                    return 1'b0;
                end
                return close_header(r);
            end
            PH_MASK: begin
                key_word = {key_word[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left != 4'd0) return 1'b0;
                return close_header(r);
            end
            PH_PAYLOAD: begin
                if (len_left != 64'd0) len_left = len_left - 64'd1;
                if (dropping) begin
                    if (len_left == 64'd0) begin
                        dropping = 1'b0;
                        ph = PH_HDR0;
                    end
                    return 1'b0;
                end
                d = b;
                if (cur_masked) d = b ^ key_word[8 * (3 - int'(key_pos)) +: 8];
                key_pos = key_pos + 2'd1;
                if (len_left == 64'd0) ph = PH_HDR0;
                r.data_byte    = d;
                r.has_data     = 1'b1;
                r.opcode       = cur_op;
                r.fin          = cur_fin;
                r.was_masked   = cur_masked;
                r.frame_end    = (len_left == 64'd0);
                r.length_error = 1'b0;
                return 1'b1;
            end
            default: begin
                cur_fin = b[7];
                cur_op  = b[3:0];
                ph = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Predict each accepted request, then check the oldest pending result
    always @(posedge i_clk) begin : scoreboard
        t_result   pred;
        t_result   want;
        byte_tag_t tag;
        bit        got;
        if (!i_rst_n) begin
            ph         = PH_HDR0;
            cur_op     = '0;
            cur_fin    = 1'b0;
            cur_masked = 1'b0;
            hdr_left   = '0;
            len_left   = '0;
            key_word   = '0;
            key_pos    = '0;
            dropping   = 1'b0;
            lim_len    = MAX_LEN_RST;
        end else begin
            if (cfg_wr_en) lim_len = cfg_wr_data;
            if (in_if.valid && in_if.ready) begin
                tag = pending_tags.pop_front();
                got = deframe_step(in_if.in_byte, pred);
                if (tag.typed) exp_results.insert(exp_results.size(), tag.res);
                else if (got) exp_results.insert(exp_results.size(), pred);
            end
            if (out_if.valid && out_if.ready) begin
                if (exp_results.size() == 0) begin
                    $error("deframer result with no pending expectation");
                    mismatches++;
                end else begin
                    want = exp_results.pop_front();
                    check_field("data_byte", want.data_byte, out_if.data_byte);
                    check_field("has_data", want.has_data, out_if.has_data);
                    check_field("opcode", want.opcode, out_if.opcode);
                    check_field("fin", want.fin, out_if.fin);
                    check_field("was_masked", want.was_masked, out_if.was_masked);
                    check_field("frame_end", want.frame_end, out_if.frame_end);
                    check_field("length_error", want.length_error, out_if.length_error);
                end
            end
        end
    end

    // Randomly hold off the result channel
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold until taken
    task automatic push_byte(input logic [7:0] b, input bit typed, input t_result res);
        byte_tag_t tag;
        tag.typed = typed;
        tag.res   = res;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pending_tags.insert(pending_tags.size(), tag);
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Serialize a frame; the typed result rides on the byte that ends the header
    task automatic send_frame(input frame_t f);
        logic [6:0] len7;
        int         n_ext;
        t_result    hres;
        hres = header_only(f.op, f.fin, f.masked, f.lerr);
        case (f.form)
            LEN_SHORT: begin
                len7  = f.len[6:0];
                n_ext = 0;
            end
            LEN_EXT16: begin
                len7  = EXT16_CODE;
                n_ext = int'(EXT16_BYTES);
            end
            default: begin
                len7  = EXT64_CODE;
                n_ext = int'(EXT64_BYTES);
            end
        endcase
        push_byte({f.fin, f.rsv, f.op}, 1'b0, hres);
        push_byte({f.masked, len7}, f.typed && !f.masked && n_ext == 0, hres);
        for (int i = n_ext - 1; i >= 0; i--)
            push_byte(f.len[8 * i +: 8], f.typed && !f.masked && i == 0, hres);
        if (f.masked) begin
            for (int i = 3; i >= 0; i--)
                push_byte(f.key[8 * i +: 8], f.typed && i == 0, hres);
        end
        repeat (f.npay) push_byte(8'($urandom_range(255)), 1'b0, hres);
    endtask

    // Well-formed frame with random header, length form and content
    function automatic frame_t rand_frame();
        frame_t f;
        int     r;
        f = '0;
        r = $urandom_range(99);
        if (r < 55)      f.op = 4'($urandom_range(2));
        else if (r < 80) f.op = OP_CLOSE + 4'($urandom_range(2));
        else             f.op = 4'($urandom_range(15));
        f.fin    = 1'($urandom_range(1));
        f.rsv    = 3'($urandom_range(7));
        f.masked = 1'($urandom_range(1));
        f.key    = $urandom;
        r = $urandom_range(99);
        if (r < 50) begin
            f.len = $urandom_range(12);
        end else if (r < 60) begin
            f.len = 0;
        end else if (r < 75 && cur_max_len <= 200) begin
            // straddle the limit: one below, equal, one above
            if (cur_max_len == 0) f.len = $urandom_range(1);
            else f.len = cur_max_len - 1 + $urandom_range(2);
        end else if (r < 88) begin
            f.len = $urandom_range(125, 100);
        end else begin
            f.len = $urandom_range(180, 126);
        end
        r = $urandom_range(9);
        if (f.len > 125) f.form = (r < 6) ? LEN_EXT16 : LEN_EXT64;
        else if (r < 6)  f.form = LEN_SHORT;
        else if (r < 8)  f.form = LEN_EXT16;
        else             f.form = LEN_EXT64;
        f.npay = int'(f.len);
        return f;
    endfunction

    // Stop feeding, let every expected result arrive, then let the pipe settle
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [31:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        cur_max_len = v;
    endtask

    initial begin : stimulus
        int          target;
        logic [31:0] lim;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        i_rst_n       = 1'b0;
        src_idle_pct  = IDLE_LO;
        snk_idle_pct  = IDLE_HI;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed frames
        foreach (dir_frames[i]) begin
            if (dir_frames[i].set_cfg) write_max_len(dir_frames[i].cfg);
            send_frame(dir_frames[i]);
        end

        // Random frames: three idle patterns, three limits each
        for (int m = 0; m < 3; m++) begin
            if (m == 0) begin
                src_idle_pct = IDLE_LO;
                snk_idle_pct = IDLE_HI;
            end else if (m == 1) begin
                src_idle_pct = IDLE_HI;
                snk_idle_pct = IDLE_LO;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            for (int s = 0; s < 3; s++) begin
                lim = seg_lims[3 * m + s];
                if (3 * m + s == 8) lim = $urandom_range(300);
                write_max_len(lim);
                target = bytes_sent + SEG_BYTES;
                while (bytes_sent < target) send_frame(rand_frame());
            end
        end

        // Last: a saturated length swallows whatever follows
        send_frame(ceil_frame);
        drain_results();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[websocket_frame_deframer_top.f]
hdl/wsd_pkg.sv
hdl/wsd_if.sv
hdl/wsd_in_stage.sv
hdl/wsd_parser.sv
hdl/wsd_out_stage.sv
hdl/websocket_frame_deframer_top.sv
hdl/wsd_checker.sv
verif/websocket_frame_deframer_top_test.sv
